// ===== rtl/core/u8shift_pkg.sv =====
// Package for the UTF-8 to shift-symbol encoder.
// Holds the queue entry type, symbol constants and the token lookup functions.
// No dependencies.
package u8shift_pkg;

   localparam int SYMBOL_W    = 6;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [SYMBOL_W-1:0] SHIFT_SYMBOL = 6'd63;
   localparam logic [SYMBOL_W-1:0] REPLACE_CODE = 6'd17;
   localparam logic [COUNT_W-1:0]  MAX_SYMBOLS_RESET = 8'd127;

   typedef struct packed {
      logic [SYMBOL_W-1:0] sym0;
      logic [SYMBOL_W-1:0] sym1;
      logic                two;
      logic                too_long;
      logic                eot;
   } entry_type;

   typedef struct packed {
      logic                two;
      logic [SYMBOL_W-1:0] code;
   } single_enc_type;

   function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [2:0] len;
      len = 3'd1;
      if ((b & 8'h80) == 8'h00) begin
         len = 3'd1;
      end else if ((b & 8'hE0) == 8'hC0) begin
         len = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
         len = 3'd3;
      end else if ((b & 8'hF8) == 8'hF0) begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic single_enc_type encode_single(input logic [BYTE_W-1:0] b);
      single_enc_type r;
      r.two  = 1'b0;
      r.code = '0;
      if (b == 8'h20) begin
         r.code = 6'd0;
      end else if (b >= 8'h61 && b <= 8'h7A) begin
         r.code = SYMBOL_W'(b - 8'h60);
      end else if (b >= 8'h30 && b <= 8'h39) begin
         r.code = SYMBOL_W'(b - 8'd21);
      end else if (b >= 8'h41 && b <= 8'h5A) begin
         r.code = SYMBOL_W'(b - 8'd28);
      end else begin
         r.two = 1'b1;
         case (b)
            8'h0A: r.code = 6'd0;
            8'h2E: r.code = 6'd15;
            8'h2C: r.code = 6'd16;
            8'h3F: r.code = 6'd17;
            8'h21: r.code = 6'd18;
            8'h3A: r.code = 6'd19;
            8'h3B: r.code = 6'd20;
            8'h27: r.code = 6'd21;
            8'h22: r.code = 6'd22;
            8'h2D: r.code = 6'd23;
            8'h5F: r.code = 6'd24;
            8'h2F: r.code = 6'd25;
            8'h5C: r.code = 6'd26;
            8'h2B: r.code = 6'd27;
            8'h3D: r.code = 6'd28;
            8'h2A: r.code = 6'd29;
            8'h25: r.code = 6'd30;
            8'h26: r.code = 6'd31;
            8'h23: r.code = 6'd32;
            8'h40: r.code = 6'd33;
            8'h24: r.code = 6'd34;
            8'h3C: r.code = 6'd35;
            8'h3E: r.code = 6'd36;
            8'h28: r.code = 6'd37;
            8'h29: r.code = 6'd38;
            8'h5B: r.code = 6'd39;
            8'h5D: r.code = 6'd40;
            8'h7B: r.code = 6'd41;
            8'h7D: r.code = 6'd42;
            8'h7C: r.code = 6'd43;
            8'h60: r.code = 6'd57;
            8'h7E: r.code = 6'd58;
            8'h5E: r.code = 6'd59;
            default: r.code = REPLACE_CODE;
         endcase
      end
      return r;
   endfunction

   function automatic logic [SYMBOL_W-1:0] pair_code(input logic [BYTE_W-1:0] lead,
                                                     input logic [BYTE_W-1:0] trail);
      logic [SYMBOL_W-1:0] c;
      c = REPLACE_CODE;
      if (lead == 8'hC2 && trail == 8'hB0) begin
         c = 6'd60;
      end else if (lead == 8'hC3) begin
         case (trail)
            8'hA1: c = 6'd1;
            8'hA0: c = 6'd2;
            8'hA2: c = 6'd3;
            8'hA3: c = 6'd4;
            8'hA9: c = 6'd5;
            8'hAA: c = 6'd6;
            8'hAD: c = 6'd7;
            8'hB3: c = 6'd8;
            8'hB4: c = 6'd9;
            8'hB5: c = 6'd10;
            8'hBA: c = 6'd11;
            8'hBC: c = 6'd12;
            8'hA7: c = 6'd13;
            8'hB1: c = 6'd14;
            8'h81: c = 6'd44;
            8'h82: c = 6'd45;
            8'h83: c = 6'd46;
            8'h89: c = 6'd47;
            8'h8A: c = 6'd48;
            8'h8D: c = 6'd49;
            8'h93: c = 6'd50;
            8'h94: c = 6'd51;
            8'h95: c = 6'd52;
            8'h9A: c = 6'd53;
            8'h9C: c = 6'd54;
            8'h87: c = 6'd55;
            8'h91: c = 6'd56;
            default: c = REPLACE_CODE;
         endcase
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/u8shift_front.sv =====
// Front end of the UTF-8 to shift-symbol encoder: accepts bytes, tracks the
// open token and the message length, and pushes encoded tokens to the queue.
// Depends on u8shift_pkg.
module u8shift_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [u8shift_pkg::COUNT_W-1:0]     csr_max_symbols,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [u8shift_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                                req_end_of_text,
   output logic                                push,
   output u8shift_pkg::entry_type              push_entry
);

   logic [u8shift_pkg::COUNT_W-1:0] max_symbols_ff, max_symbols_in;
   logic [1:0]                      pending_ff, pending_in;
   logic [u8shift_pkg::BYTE_W-1:0]  lead_ff, lead_in;
   logic [2:0]                      size_ff, size_in;
   logic [u8shift_pkg::COUNT_W-1:0] sent_ff, sent_in;
   logic                            dropping_ff, dropping_in;

   logic                             accept;
   logic                             emit;
   logic                             two;
   logic [u8shift_pkg::SYMBOL_W-1:0] s0, s1;
   logic [2:0]                       len;
   logic [1:0]                       pend_dec;
   logic [u8shift_pkg::COUNT_W:0]    total;
   u8shift_pkg::single_enc_type      single;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign len       = u8shift_pkg::lead_length(req_data_byte);
   assign single    = u8shift_pkg::encode_single(req_data_byte);
   assign pend_dec  = pending_ff - 2'd1;

   always_comb begin
      max_symbols_in = max_symbols_ff;
      pending_in     = pending_ff;
      lead_in        = lead_ff;
      size_in        = size_ff;
      sent_in        = sent_ff;
      dropping_in    = dropping_ff;
      emit           = 1'b0;
      two            = 1'b1;
      s0             = u8shift_pkg::SHIFT_SYMBOL;
      s1             = u8shift_pkg::REPLACE_CODE;
      push           = 1'b0;
      push_entry     = '0;
      total          = '0;

      if (csr_valid && csr_ready) begin
         max_symbols_in = csr_max_symbols;
      end

      if (accept) begin
         if (dropping_ff) begin
            if (req_end_of_text) begin
               sent_in     = '0;
               dropping_in = 1'b0;
            end
         end else if (pending_ff == 2'd0) begin
            if (len == 3'd1) begin
               emit = 1'b1;
               if (!single.two) begin
                  two = 1'b0;
                  s0  = single.code;
               end else begin
                  s1 = single.code;
               end
            end else if (req_end_of_text) begin
               emit = 1'b1;
            end else begin
               lead_in    = req_data_byte;
               size_in    = len;
               pending_in = 2'(len - 3'd1);
            end
         end else begin
            if (size_ff == 3'd2) begin
               emit = 1'b1;
               s1   = u8shift_pkg::pair_code(lead_ff, req_data_byte);
            end else if (pend_dec == 2'd0 || req_end_of_text) begin
               emit = 1'b1;
            end else begin
               pending_in = pend_dec;
            end
         end

         if (emit) begin
            pending_in = '0;
            lead_in    = '0;
            size_in    = '0;
            push       = 1'b1;
            total      = {1'b0, sent_ff} + (two ? 9'd2 : 9'd1);
            if (total > {1'b0, max_symbols_ff}) begin
               push_entry.too_long = 1'b1;
               push_entry.eot      = 1'b1;
               sent_in             = '0;
               dropping_in         = !req_end_of_text;
            end else begin
               push_entry.sym0 = s0;
               push_entry.sym1 = s1;
               push_entry.two  = two;
               push_entry.eot  = req_end_of_text;
               sent_in         = req_end_of_text ? '0 : total[u8shift_pkg::COUNT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_symbols_ff <= u8shift_pkg::MAX_SYMBOLS_RESET;
         pending_ff     <= '0;
         lead_ff        <= '0;
         size_ff        <= '0;
         sent_ff        <= '0;
         dropping_ff    <= 1'b0;
      end else begin
         max_symbols_ff <= max_symbols_in;
         pending_ff     <= pending_in;
         lead_ff        <= lead_in;
         size_ff        <= size_in;
         sent_ff        <= sent_in;
         dropping_ff    <= dropping_in;
      end
   end

   a_drop_no_token: assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> pending_ff == 2'd0 && sent_ff == '0)
      else $error("token open while dropping");

   a_drop_no_push: assert property (@(posedge clock) disable iff (reset)
      dropping_ff && !(req_valid && req_ready && req_end_of_text) |=> dropping_ff)
      else $error("drop mode left before message end");

   a_overflow_enters_drop: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.too_long && !req_end_of_text |=> dropping_ff)
      else $error("overflow did not start drop mode");

endmodule

// ===== rtl/core/u8shift_queue.sv =====
// Two-entry queue between the front end and the symbol emitter.
// Depends on u8shift_pkg.
module u8shift_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  u8shift_pkg::entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output u8shift_pkg::entry_type head
);

   u8shift_pkg::entry_type                 slot_ff [u8shift_pkg::QUEUE_DEPTH];
   logic [u8shift_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [u8shift_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [u8shift_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                                   do_push, do_pop;

   assign full      = count_ff == u8shift_pkg::QUEUE_CNT_W'(u8shift_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/u8shift_back.sv =====
// Symbol emitter: pops encoded tokens and presents one symbol per transaction
// from a registered output stage. Depends on u8shift_pkg.
module u8shift_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             not_empty,
   input  u8shift_pkg::entry_type           head,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [u8shift_pkg::SYMBOL_W-1:0] rsp_symbol,
   output logic                             rsp_run_last,
   output logic                             rsp_message_end,
   output logic                             rsp_too_long
);

   logic                             valid_ff, valid_in;
   logic [u8shift_pkg::SYMBOL_W-1:0] symbol_ff, symbol_in;
   logic                             run_last_ff, run_last_in;
   logic                             msg_end_ff, msg_end_in;
   logic                             too_long_ff, too_long_in;
   logic                             second_ff, second_in;
   logic [u8shift_pkg::SYMBOL_W-1:0] second_sym_ff, second_sym_in;
   logic                             second_eot_ff, second_eot_in;
   logic                             load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in      = valid_ff;
      symbol_in     = symbol_ff;
      run_last_in   = run_last_ff;
      msg_end_in    = msg_end_ff;
      too_long_in   = too_long_ff;
      second_in     = second_ff;
      second_sym_in = second_sym_ff;
      second_eot_in = second_eot_ff;
      pop           = 1'b0;
      if (load) begin
         if (second_ff) begin
            valid_in    = 1'b1;
            symbol_in   = second_sym_ff;
            run_last_in = 1'b1;
            msg_end_in  = second_eot_ff;
            too_long_in = 1'b0;
            second_in   = 1'b0;
         end else if (not_empty) begin
            pop         = 1'b1;
            valid_in    = 1'b1;
            too_long_in = head.too_long;
            if (head.too_long) begin
               symbol_in   = '0;
               run_last_in = 1'b1;
               msg_end_in  = 1'b1;
            end else if (head.two) begin
               symbol_in     = head.sym0;
               run_last_in   = 1'b0;
               msg_end_in    = 1'b0;
               second_in     = 1'b1;
               second_sym_in = head.sym1;
               second_eot_in = head.eot;
            end else begin
               symbol_in   = head.sym0;
               run_last_in = 1'b1;
               msg_end_in  = head.eot;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff     <= symbol_in;
      run_last_ff   <= run_last_in;
      msg_end_ff    <= msg_end_in;
      too_long_ff   <= too_long_in;
      second_sym_ff <= second_sym_in;
      second_eot_ff <= second_eot_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_symbol      = symbol_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_message_end = msg_end_ff;
   assign rsp_too_long    = too_long_ff;

   a_overflow_shape: assert property (@(posedge clock) disable iff (reset)
      valid_ff && too_long_ff |-> symbol_ff == '0 && run_last_ff && msg_end_ff)
      else $error("malformed overflow transaction");

   a_second_behind_first: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> valid_ff && !run_last_ff && symbol_ff == u8shift_pkg::SHIFT_SYMBOL)
      else $error("second symbol pending without shift symbol shown");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && msg_end_ff |-> run_last_ff)
      else $error("message end on a non-final symbol");

endmodule

// ===== rtl/core/utf8_text_to_shift_symbols_top.sv =====
// Top level of the UTF-8 to shift-symbol encoder.
// Instantiates u8shift_front, u8shift_queue and u8shift_back; uses u8shift_pkg.
//
// Usage:
//   req_*  : one UTF-8 byte per transaction, req_end_of_text on the last byte
//            of a message. Bytes are taken while the two-entry token queue has
//            room, so a byte can follow in the next cycle.
//   rsp_*  : one six-bit symbol per transaction. A token gives one or two
//            symbols (shift symbol 63, then a code); rsp_run_last marks the
//            final symbol of a token, rsp_message_end the final one of a
//            message. An overflow past max_symbols gives one transaction with
//            rsp_too_long set and drops the rest of the message.
//   csr_*  : writes max_symbols (reset 127); always ready, write only while idle.
// The first symbol of a token is registered in a queue slot and then in the output register.
// Throughput: one symbol per cycle at the output register while rsp_ready is high, so a
//   token that maps to two symbols holds the emitter for both; the symbol emitter sets this rate.
// Reset clears all message state and the queue; no symbol is pending.
// When rsp_ready is low, the output register holds, the queue fills, and then
//   req_ready drops until the emitter drains an entry.
module utf8_text_to_shift_symbols_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [u8shift_pkg::COUNT_W-1:0]  csr_max_symbols,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [u8shift_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                             req_end_of_text,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [u8shift_pkg::SYMBOL_W-1:0] rsp_symbol,
   output logic                             rsp_run_last,
   output logic                             rsp_message_end,
   output logic                             rsp_too_long
);

   logic                   push, pop, full, not_empty;
   u8shift_pkg::entry_type push_entry, head;

   assign req_ready = !full;

   u8shift_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_symbols (csr_max_symbols),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .push            (push),
      .push_entry      (push_entry)
   );

   u8shift_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   u8shift_back u_back (
      .clock           (clock),
      .reset           (reset),
      .not_empty       (not_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end),
      .rsp_too_long    (rsp_too_long)
   );

endmodule
